/* rtl/prs_pkg.sv */
// PRESENT-128 package: S-boxes, permutation layers, key schedule step.
// No dependencies.
`default_nettype none
package prs_pkg;
	localparam int unsigned BlockW = 64;
	localparam int unsigned KeyW = 128;
	localparam int unsigned Rounds = 31;
	localparam int unsigned CtrW = 5;

	typedef logic [BlockW-1:0] block_t;
	typedef logic [KeyW-1:0] key_t;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1
	} reg_idx_t;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	function automatic logic [3:0] sbox(input logic [3:0] x);
		logic [3:0] r;
		case (x)
			4'h0: r = 4'hC; 4'h1: r = 4'h5; 4'h2: r = 4'h6; 4'h3: r = 4'hB;
			4'h4: r = 4'h9; 4'h5: r = 4'h0; 4'h6: r = 4'hA; 4'h7: r = 4'hD;
			4'h8: r = 4'h3; 4'h9: r = 4'hE; 4'hA: r = 4'hF; 4'hB: r = 4'h8;
			4'hC: r = 4'h4; 4'hD: r = 4'h7; 4'hE: r = 4'h1; default: r = 4'h2;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] sbox_inv(input logic [3:0] x);
		logic [3:0] r;
		case (x)
			4'h0: r = 4'h5; 4'h1: r = 4'hE; 4'h2: r = 4'hF; 4'h3: r = 4'h8;
			4'h4: r = 4'hC; 4'h5: r = 4'h1; 4'h6: r = 4'h2; 4'h7: r = 4'hD;
			4'h8: r = 4'hB; 4'h9: r = 4'h4; 4'hA: r = 4'h6; 4'hB: r = 4'h3;
			4'hC: r = 4'h0; 4'hD: r = 4'h7; 4'hE: r = 4'h9; default: r = 4'hA;
		endcase
		return r;
	endfunction

	function automatic int unsigned perm_pos(input int unsigned i);
		return (i == 63) ? 63 : (16 * i) % 63;
	endfunction

	function automatic block_t sub_layer(input block_t s, input logic inv);
		block_t r;
		for (int n = 0; n < 16; n++)
			r[4*n +: 4] = inv ? sbox_inv(s[4*n +: 4]) : sbox(s[4*n +: 4]);
		return r;
	endfunction

	function automatic block_t perm_layer(input block_t s);
		block_t r;
		for (int unsigned i = 0; i < 64; i++)
			r[perm_pos(i)] = s[i];
		return r;
	endfunction

	function automatic block_t perm_layer_inv(input block_t s);
		block_t r;
		for (int unsigned i = 0; i < 64; i++)
			r[i] = s[perm_pos(i)];
		return r;
	endfunction

	// forward key update with round counter ctr
	function automatic key_t key_next(input key_t k, input logic [CtrW-1:0] ctr);
		key_t r;
		r = {k[66:0], k[127:67]};
		r[127:124] = sbox(r[127:124]);
		r[123:120] = sbox(r[123:120]);
		r[66:62] = r[66:62] ^ ctr;
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/prs_stream_if.sv */
// Valid/ready channel carrying a payload of type payload_t.
// No dependencies.
`default_nettype none
interface prs_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/prs_cell.sv */
// Pipeline cell: encryption round or decrypt pass-through, plus key advance.
// Depends on prs_pkg.
`default_nettype none
module prs_cell #(
	parameter int unsigned RoundIdx = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire logic op_in,
	input  wire prs_pkg::block_t state_in,
	input  wire prs_pkg::key_t enc_key_in,
	output logic valid_q,
	output logic op_q,
	output prs_pkg::block_t state_q,
	output prs_pkg::key_t enc_key_q
);
	import prs_pkg::*;
	// key register advances one schedule step per cell in both directions;
	// decryption only passes its block along here
	localparam logic [CtrW-1:0] Ctr = CtrW'(RoundIdx + 1);
	block_t nxt;
	always_comb begin
		if (op_in == OP_ENCRYPT)
			nxt = perm_layer(sub_layer(state_in ^ enc_key_in[127:64], 1'b0));
		else
			nxt = state_in;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_q <= op_in;
			state_q <= nxt;
			enc_key_q <= key_next(enc_key_in, Ctr);
		end
	end
endmodule
`default_nettype wire

/* rtl/present128_block_cipher_core.sv */
// PRESENT-128 top level: key registers, pipeline of round cells, output stage.
// Depends on prs_pkg, prs_stream_if, prs_cell.
`default_nettype none
// Fully pipelined PRESENT-128 cipher accepting one transaction per cycle while not
// stalled. Encryption flows through a chain of 31 round cells and a final whitening
// stage; decryption first expands the key through 31 key-schedule cells, then runs
// 31 inverse round cells and a final whitening stage. Both directions share one
// chain of 63 stages plus the output register. The key in force when a block is
// accepted is captured with it. The pipeline stalls as a whole when the output is
// not taken.
module present128_block_cipher_core (
	input  wire logic clk,
	input  wire logic arst_n,
	prs_stream_if.sink in_ch,
	prs_stream_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import prs_pkg::*;
	localparam int unsigned Depth = 2 * Rounds + 1;

	logic [63:0] key_high_q, key_low_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				1'(REG_KEY_HIGH): key_high_q <= cfg_data;
				default: key_low_q <= cfg_data;
			endcase
		end
	end

	// stage arrays; stage 0 is input
	logic vld [Depth+1];
	logic opx [Depth+1];
	block_t st [Depth+1];
	key_t ek [Depth+1];
	logic en;

	logic out_valid_q;
	block_t out_q;
	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// payload: {operation, block_in}
	assign vld[0] = in_ch.valid;
	assign opx[0] = in_ch.payload[64];
	assign st[0] = in_ch.payload[63:0];
	assign ek[0] = {key_high_q, key_low_q};

	// Encryption: stages 1..31 rounds, 32 whitening, then pass-through cells.
	// Decryption: stages 1..31 expand the key only, 32..62 inverse rounds.
	for (genvar g = 0; g < Depth; g++) begin : g_chain
		if (g < Rounds) begin : g_fwd
			prs_cell #(.RoundIdx(g)) u_cell (
				.clk, .arst_n, .en,
				.valid_in(vld[g]), .op_in(opx[g]), .state_in(st[g]),
				.enc_key_in(ek[g]),
				.valid_q(vld[g+1]), .op_q(opx[g+1]), .state_q(st[g+1]),
				.enc_key_q(ek[g+1])
			);
		end else begin : g_tail
			// stage g: enc does final whiten at g==Rounds; dec inverse rounds
			// use ek as the decreasing key, kept by stepping back in a register
			block_t nxt;
			key_t kprev;
			localparam int unsigned R = g - Rounds; // 0..31
			always_comb begin
				kprev = ek[g];
				if (opx[g] == OP_ENCRYPT) begin
					nxt = (R == 0) ? st[g] ^ ek[g][127:64] : st[g];
				end else if (R < Rounds) begin
					nxt = sub_layer(perm_layer_inv(st[g] ^ ek[g][127:64]), 1'b1);
					// inverse schedule step with counter 31-R
					kprev[66:62] = kprev[66:62] ^ CtrW'(Rounds - R);
					kprev[127:124] = sbox_inv(kprev[127:124]);
					kprev[123:120] = sbox_inv(kprev[123:120]);
					kprev = {kprev[60:0], kprev[127:61]};
				end else begin
					nxt = st[g] ^ ek[g][127:64];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld[g+1] <= 1'b0;
				else if (en) vld[g+1] <= vld[g];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					opx[g+1] <= opx[g];
					st[g+1] <= nxt;
					ek[g+1] <= kprev;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= vld[Depth];
	end
	always_ff @(posedge clk) begin
		if (en) out_q <= st[Depth];
	end
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("result dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld[Depth] |=> out_valid_q)
		else $error("pipeline result lost");
endmodule
`default_nettype wire
